### design/m3i_pkg.sv
// m3i_pkg: types and constants shared by the 3x3 matrix inverse block
// no dependencies; used by every module of the block

package m3i_pkg;

    localparam int ELEM_W      = 32;   // q16.16 element width
    localparam int COF_W       = 65;   // signed cofactor, q32.32
    localparam int CMAG_W      = 64;   // cofactor magnitude
    localparam int DET_W       = 97;   // signed determinant, q48.48
    localparam int DMAG_W      = 96;   // determinant magnitude
    localparam int PSUM_W      = 67;   // sum of three 65-bit partial products
    localparam int NLANE       = 9;    // one lane per matrix element
    localparam int QBITS       = 32;   // quotient bits formed by the divider
    localparam int FRONT_STG   = 6;    // front pipeline depth
    localparam int QUEUE_DEPTH = 2;    // default depth of the middle queue

    localparam logic [DMAG_W-1:0] DET_ONE = DMAG_W'(1) << 48;

    typedef struct packed {
        logic signed [ELEM_W-1:0] e11;
        logic signed [ELEM_W-1:0] e12;
        logic signed [ELEM_W-1:0] e13;
        logic signed [ELEM_W-1:0] e21;
        logic signed [ELEM_W-1:0] e22;
        logic signed [ELEM_W-1:0] e23;
        logic signed [ELEM_W-1:0] e31;
        logic signed [ELEM_W-1:0] e32;
        logic signed [ELEM_W-1:0] e33;
    } t_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] r11;
        logic signed [ELEM_W-1:0] r12;
        logic signed [ELEM_W-1:0] r13;
        logic signed [ELEM_W-1:0] r21;
        logic signed [ELEM_W-1:0] r22;
        logic signed [ELEM_W-1:0] r23;
        logic signed [ELEM_W-1:0] r31;
        logic signed [ELEM_W-1:0] r32;
        logic signed [ELEM_W-1:0] r33;
        logic                     singular;
        logic                     clipped;
    } t_out;

    // adjugate in output order, as sign and magnitude, plus the divisor and a singular flag
    typedef struct packed {
        logic [DMAG_W-1:0]             dmag;
        logic                          dneg;
        logic                          sing;
        logic [NLANE-1:0][CMAG_W-1:0]  cmag;
        logic [NLANE-1:0]              cneg;
    } t_mid;

endpackage

### design/matrix3x3_inverse.sv
// matrix3x3_inverse: 3x3 q16.16 inverse by adjugate over determinant
// throughput: one item per cycle while results are popped as they show;
// set by the fully pipelined front and divider
// the 32-stage divider forms one quotient bit per stage in each of nine lanes
// reset (synchronous, active low) clears all valid bits, queue pointers and count only
// depends on m3i_pkg, m3i_front, m3i_queue, m3i_back

module matrix3x3_inverse #(
    parameter int QUEUE_DEPTH = m3i_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  m3i_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output m3i_pkg::t_out o_item
);

    // front to queue
    logic          w_f_push;
    m3i_pkg::t_mid w_f_mid;
    logic          w_q_full;
    // queue to back
    logic          w_q_pop;
    logic          w_q_empty;
    m3i_pkg::t_mid w_q_mid;

    // front: products, cofactors, determinant, sign and magnitude split
    m3i_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (w_q_full),
        .o_full   (full),
        .o_push   (w_f_push),
        .o_mid    (w_f_mid)
    );

    // queue lets the front keep going while the result side stalls briefly
    m3i_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_data  (w_f_mid),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_mid),
        .o_empty (w_q_empty)
    );

    // back: divide each adjugate entry by the determinant, saturate, hold result
    m3i_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_mid     (w_q_mid),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_item)
    );

endmodule

### design/m3i_front.sv
// m3i_front: cofactor and determinant pipeline, six stages
// depends on m3i_pkg

module m3i_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  m3i_pkg::t_in  i_item,
    input  logic          i_q_full,
    output logic          o_full,
    output logic          o_push,
    output m3i_pkg::t_mid o_mid
);

    localparam int EW = m3i_pkg::ELEM_W;
    localparam int CW = m3i_pkg::COF_W;
    localparam int PW = m3i_pkg::PSUM_W;
    localparam int DW = m3i_pkg::DET_W;
    localparam int MW = m3i_pkg::DMAG_W;
    localparam int NS = m3i_pkg::FRONT_STG;

    // cofactor k = a[PA]*a[PB] - a[PC]*a[PD]
    localparam int unsigned PA [9] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
    localparam int unsigned PB [9] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
    localparam int unsigned PC [9] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
    localparam int unsigned PD [9] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

    logic                   w_en;
    logic signed [EW-1:0]   w_a [9];
    logic [NS-1:0]          r_v;

    logic signed [2*EW-1:0] r_p1 [9];
    logic signed [2*EW-1:0] r_p2 [9];
    logic signed [EW-1:0]   r_a1 [3];
    logic signed [CW-1:0]   r_c2 [9];
    logic signed [EW-1:0]   r_a2 [3];
    logic signed [CW-1:0]   r_c3 [9];
    logic signed [CW-1:0]   r_plo [3];
    logic signed [CW-1:0]   r_phi [3];
    logic signed [CW-1:0]   r_c4 [9];
    logic signed [PW-1:0]   r_hs;
    logic signed [PW-1:0]   r_ls;
    logic signed [CW-1:0]   r_c5 [9];
    logic signed [DW-1:0]   r_det;
    logic signed [DW:0]     w_det;
    logic signed [DW-1:0]   w_ndet;
    m3i_pkg::t_mid          r_mid;
    m3i_pkg::t_mid          w_mid;

    assign w_en   = !r_v[NS-1] || !i_q_full;
    assign o_full = !w_en;
    assign o_push = r_v[NS-1] && !i_q_full;
    assign o_mid  = r_mid;

    assign w_a[0] = i_item.e11;
    assign w_a[1] = i_item.e12;
    assign w_a[2] = i_item.e13;
    assign w_a[3] = i_item.e21;
    assign w_a[4] = i_item.e22;
    assign w_a[5] = i_item.e23;
    assign w_a[6] = i_item.e31;
    assign w_a[7] = i_item.e32;
    assign w_a[8] = i_item.e33;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NS-2:0], i_push};
        end
    end

    // combine high and low partial sums into the determinant
    assign w_det = ({{(DW+1-PW){r_hs[PW-1]}}, r_hs} <<< 32)
                 + {{(DW+1-PW){r_ls[PW-1]}}, r_ls};
    assign w_ndet = -r_det;

    always_comb begin
        w_mid.sing = (r_det == '0);
        w_mid.dneg = r_det[DW-1];
        if (r_det == '0) begin
            w_mid.dmag = m3i_pkg::DET_ONE;
        end else if (r_det[DW-1]) begin
            w_mid.dmag = w_ndet[MW-1:0];
        end else begin
            w_mid.dmag = r_det[MW-1:0];
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_cof
        localparam int CI = 3 * (k % 3) + (k / 3);   // transpose to adjugate
        logic signed [CW-1:0] w_nc;
        assign w_nc = -r_c5[CI];
        assign w_mid.cneg[k] = r_c5[CI][CW-1];
        assign w_mid.cmag[k] = r_c5[CI][CW-1] ? w_nc[CW-2:0] : r_c5[CI][CW-2:0];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_p1[k] <= w_a[PA[k]] * w_a[PB[k]];
                r_p2[k] <= w_a[PC[k]] * w_a[PD[k]];
                r_c2[k] <= $signed({r_p1[k][2*EW-1], r_p1[k]})
                         - $signed({r_p2[k][2*EW-1], r_p2[k]});
                r_c3[k] <= r_c2[k];
                r_c4[k] <= r_c3[k];
                r_c5[k] <= r_c4[k];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_det
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_a1[k]  <= w_a[k];
                r_a2[k]  <= r_a1[k];
                r_plo[k] <= r_a2[k] * $signed({1'b0, r_c2[k][EW-1:0]});
                r_phi[k] <= r_a2[k] * $signed(r_c2[k][CW-1:EW]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hs  <= PW'(r_phi[0]) + PW'(r_phi[1]) + PW'(r_phi[2]);
            r_ls  <= PW'(r_plo[0]) + PW'(r_plo[1]) + PW'(r_plo[2]);
            r_det <= w_det[DW-1:0];
            r_mid <= w_mid;
        end
    end

endmodule

### design/m3i_queue.sv
// m3i_queue: short register queue between front and back
// depends on m3i_pkg

module m3i_queue #(
    parameter int DEPTH = m3i_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  m3i_pkg::t_mid i_data,
    output logic          o_full,
    input  logic          i_pop,
    output m3i_pkg::t_mid o_data,
    output logic          o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    m3i_pkg::t_mid r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### design/m3i_back.sv
// m3i_back: range check, 32-step pipelined divider and saturation
// depends on m3i_pkg

module m3i_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  m3i_pkg::t_mid i_mid,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output m3i_pkg::t_out o_item
);

    localparam int NL = m3i_pkg::NLANE;
    localparam int NQ = m3i_pkg::QBITS;
    localparam int MW = m3i_pkg::DMAG_W;
    localparam int CM = m3i_pkg::CMAG_W;
    localparam int EW = m3i_pkg::ELEM_W;

    logic                w_en;
    logic [NQ:0]         r_bv;
    logic [MW-1:0]       r_den  [NQ+1];
    logic                r_sing [NQ+1];
    logic [MW-1:0]       r_rem  [NQ+1][NL];
    logic [NQ-1:0]       r_q    [NQ+1][NL];
    logic                r_big  [NQ+1][NL];
    logic                r_neg  [NQ+1][NL];
    logic [EW-1:0]       w_val  [NL];
    logic [NL-1:0]       w_clip;
    m3i_pkg::t_out       w_res;
    m3i_pkg::t_out       r_out;
    logic                r_vout;

    assign w_en    = !r_vout || i_pop;
    assign o_q_pop = w_en && !i_q_empty;
    assign o_empty = !r_vout;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv   <= '0;
            r_vout <= 1'b0;
        end else if (w_en) begin
            r_bv   <= {r_bv[NQ-1:0], !i_q_empty};
            r_vout <= r_bv[NQ];
        end
    end

    // entry stage: quotient of 2^32 or more is out of range at once
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_den[0]  <= i_mid.dmag;
            r_sing[0] <= i_mid.sing;
        end
    end

    for (genvar k = 0; k < NL; k++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[0][k] <= MW'(i_mid.cmag[k]);
                r_q[0][k]   <= '0;
                r_big[0][k] <= ({{(MW-CM){1'b0}}, i_mid.cmag[k]} >= i_mid.dmag);
                r_neg[0][k] <= i_mid.cneg[k] ^ i_mid.dneg;
            end
        end
    end

    // one restoring step per stage
    for (genvar s = 0; s < NQ; s++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_den[s+1]  <= r_den[s];
                r_sing[s+1] <= r_sing[s];
            end
        end
        for (genvar k = 0; k < NL; k++) begin : g_lane
            logic [MW:0] w_t;
            logic [MW:0] w_d;
            logic        w_ge;
            assign w_t  = {r_rem[s][k], 1'b0};
            assign w_d  = w_t - {1'b0, r_den[s]};
            assign w_ge = (w_t >= {1'b0, r_den[s]});
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rem[s+1][k] <= w_ge ? w_d[MW-1:0] : w_t[MW-1:0];
                    r_q[s+1][k]   <= {r_q[s][k][NQ-2:0], w_ge};
                    r_big[s+1][k] <= r_big[s][k];
                    r_neg[s+1][k] <= r_neg[s][k];
                end
            end
        end
    end

    // saturate and restore sign
    for (genvar k = 0; k < NL; k++) begin : g_sat
        logic [NQ-1:0] w_lim;
        logic [NQ-1:0] w_nq;
        assign w_lim = r_neg[NQ][k] ? {1'b1, {(NQ-1){1'b0}}} : {1'b0, {(NQ-1){1'b1}}};
        assign w_nq  = -r_q[NQ][k];
        assign w_clip[k] = r_big[NQ][k] || (r_q[NQ][k] > w_lim);
        always_comb begin
            if (w_clip[k]) begin
                w_val[k] = w_lim;
            end else if (r_neg[NQ][k]) begin
                w_val[k] = w_nq;
            end else begin
                w_val[k] = r_q[NQ][k];
            end
        end
    end

    always_comb begin
        w_res.r11      = w_val[0];
        w_res.r12      = w_val[1];
        w_res.r13      = w_val[2];
        w_res.r21      = w_val[3];
        w_res.r22      = w_val[4];
        w_res.r23      = w_val[5];
        w_res.r31      = w_val[6];
        w_res.r32      = w_val[7];
        w_res.r33      = w_val[8];
        w_res.singular = r_sing[NQ];
        w_res.clipped  = |w_clip;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_res;
        end
    end

endmodule
